/* hw/rtl/bew_pkg.sv */
package bew_pkg;

  // func codes of an input word
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // largest bit index in a byte, msb-first pixel order
  localparam logic [2:0] BIT_MAX = 3'd7;
  // bits per byte, as a 5-bit signed correction of the bit position
  localparam logic signed [4:0] BITS_PER_BYTE = 5'sd8;

  // classification of one queued command
  typedef struct packed {
    logic is_step;
    logic going_left;
    logic flat;
  } bew_kind_t;

  // divider status seen by the back end
  typedef struct packed {
    logic busy;
    logic done;
  } bew_div_stat_t;

  typedef enum logic {
    BACK_READY,
    BACK_DIVIDE
  } bew_back_state_e;

endpackage

/* hw/rtl/bew_fifo.sv */
module bew_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [PTR_BITS:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS:0] rd_ptr_q, rd_ptr_d;
  logic              do_push, do_pop;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[PTR_BITS] != rd_ptr_q[PTR_BITS]) &&
                   (wr_ptr_q[PTR_BITS-1:0] == rd_ptr_q[PTR_BITS-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q[PTR_BITS-1:0]];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[PTR_BITS-1:0]] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/bew_front.sv */
module bew_front import bew_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output bew_kind_t             kind_o,
  output logic [COORD_BITS-1:0] xs_o,
  output logic [COORD_BITS-1:0] ys_o,
  output logic [COORD_BITS-1:0] adx_o,
  output logic [COORD_BITS-1:0] dy_o
);

  logic                  swap;
  logic [COORD_BITS-1:0] xe, ye;

  always_comb begin
    // order the end points so that y grows
    swap = y_start_i > y_end_i;
    xs_o = swap ? x_end_i   : x_start_i;
    ys_o = swap ? y_end_i   : y_start_i;
    xe   = swap ? x_start_i : x_end_i;
    ye   = swap ? y_start_i : y_end_i;

    kind_o.is_step    = (func_i == FUNC_STEP);
    kind_o.going_left = xe < xs_o;
    adx_o             = kind_o.going_left ? xs_o - xe : xe - xs_o;
    dy_o              = ye - ys_o;
    kind_o.flat       = (dy_o == '0);
  end

endmodule

/* hw/rtl/bew_divider.sv */
module bew_divider import bew_pkg::*; #(
  parameter int unsigned WIDTH = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output bew_div_stat_t    stat_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CNT_BITS = $clog2(WIDTH);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0]    quo_q, quo_d;
  logic [WIDTH-1:0]    rem_q, rem_d;
  logic [WIDTH-1:0]    div_q, div_d;
  logic [WIDTH:0]      shifted;
  logic                fits;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    shifted = {rem_q, quo_q[WIDTH-1]};
    fits    = shifted >= {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(WIDTH - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[WIDTH-2:0], fits};
      rem_d = fits ? WIDTH'(shifted - {1'b0, div_q}) : shifted[WIDTH-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

/* hw/rtl/bew_back.sv */
module bew_back import bew_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ADDR_BITS  = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  stride_we_i,
  input  logic [7:0]            stride_i,
  input  logic                  cmd_valid_i,
  input  bew_kind_t             cmd_kind_i,
  input  logic [COORD_BITS-1:0] cmd_xs_i,
  input  logic [COORD_BITS-1:0] cmd_ys_i,
  input  logic [COORD_BITS-1:0] cmd_adx_i,
  input  logic [COORD_BITS-1:0] cmd_dy_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output logic [ADDR_BITS-1:0]  res_addr_o,
  output logic [2:0]            res_bit_o,
  output logic                  res_last_o
);

  localparam int unsigned QHI_BITS = (COORD_BITS - 3 > 8) ? COORD_BITS - 3 : 8;
  localparam int unsigned RS_BITS  = QHI_BITS + 2;
  localparam int unsigned ERR_BITS = COORD_BITS + 2;
  localparam int unsigned PROD_BITS = COORD_BITS + 9;

  bew_back_state_e state_q, state_d;

  logic [7:0]                  stride_q, stride_d;
  logic [7:0]                  stride_lat_q, stride_lat_d;
  logic [ADDR_BITS-1:0]        ptr_q, ptr_d;
  logic signed [4:0]           bitpos_q, bitpos_d;
  logic signed [ERR_BITS-1:0]  err_q, err_d;
  logic [COORD_BITS-1:0]       rows_left_q, rows_left_d;
  logic signed [RS_BITS-1:0]   row_step_q, row_step_d;
  logic [2:0]                  whole_q, whole_d;
  logic [COORD_BITS-1:0]       frac_q, frac_d;
  logic [COORD_BITS-1:0]       height_q, height_d;
  logic                        left_q, left_d;

  logic                        div_start;
  bew_div_stat_t               div_stat;
  logic [COORD_BITS-1:0]       quo, rem;

  logic [PROD_BITS-1:0]        start_addr;
  logic signed [ERR_BITS-1:0]  err_sum;
  logic                        err_carry;
  logic signed [4:0]           bit_sum;
  logic                        byte_inc, byte_dec;
  logic [ADDR_BITS-1:0]        ptr_adj;
  logic signed [RS_BITS-1:0]   rs_stride, rs_qhi;

  bew_divider #(
    .WIDTH(COORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_adx_i),
    .divisor_i  (cmd_dy_i),
    .stat_o     (div_stat),
    .quotient_o (quo),
    .remainder_o(rem)
  );

  assign res_addr_o = ptr_q;
  assign res_bit_o  = bitpos_q[2:0];
  assign res_last_o = (rows_left_q == COORD_BITS'(1));

  // one row of the walk
  always_comb begin
    err_sum   = err_q + ERR_BITS'(frac_q);
    err_carry = !err_sum[ERR_BITS-1];
    if (left_q) begin
      bit_sum  = bitpos_q + 5'(err_carry) + 5'(whole_q);
      byte_inc = 1'b0;
      byte_dec = !bit_sum[4];
    end else begin
      bit_sum  = bitpos_q - 5'(err_carry) - 5'(whole_q);
      byte_inc = bit_sum[4];
      byte_dec = 1'b0;
    end
    if (byte_inc) begin
      ptr_adj = ADDR_BITS'(1);
    end else if (byte_dec) begin
      ptr_adj = '1;
    end else begin
      ptr_adj = '0;
    end
  end

  assign start_addr = PROD_BITS'(stride_q) * PROD_BITS'(cmd_ys_i) +
                      PROD_BITS'(cmd_xs_i >> 3);
  assign rs_stride  = RS_BITS'(stride_lat_q);
  assign rs_qhi     = RS_BITS'(quo >> 3);

  always_comb begin
    state_d      = state_q;
    stride_d     = stride_we_i ? stride_i : stride_q;
    stride_lat_d = stride_lat_q;
    ptr_d        = ptr_q;
    bitpos_d     = bitpos_q;
    err_d        = err_q;
    rows_left_d  = rows_left_q;
    row_step_d   = row_step_q;
    whole_d      = whole_q;
    frac_d       = frac_q;
    height_d     = height_q;
    left_d       = left_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    div_start    = 1'b0;
    unique case (state_q)
      BACK_READY: begin
        if (cmd_valid_i) begin
          if (cmd_kind_i.is_step) begin
            if (rows_left_q == '0) begin
              cmd_pop_o = 1'b1;
            end else if (!res_full_i) begin
              cmd_pop_o   = 1'b1;
              res_push_o  = 1'b1;
              rows_left_d = rows_left_q - 1'b1;
              ptr_d       = ptr_q + ADDR_BITS'(row_step_q) + ptr_adj;
              err_d       = err_carry ? err_sum - ERR_BITS'(height_q) : err_sum;
              if (byte_inc) begin
                bitpos_d = bit_sum + BITS_PER_BYTE;
              end else if (byte_dec) begin
                bitpos_d = bit_sum - BITS_PER_BYTE;
              end else begin
                bitpos_d = bit_sum;
              end
            end
          end else if (cmd_kind_i.flat) begin
            cmd_pop_o   = 1'b1;
            rows_left_d = '0;
          end else begin
            cmd_pop_o    = 1'b1;
            div_start    = 1'b1;
            stride_lat_d = stride_q;
            ptr_d        = ADDR_BITS'(start_addr);
            left_d       = cmd_kind_i.going_left;
            height_d     = cmd_dy_i;
            err_d        = -ERR_BITS'(cmd_dy_i);
            rows_left_d  = cmd_dy_i;
            bitpos_d     = {{2{cmd_kind_i.going_left}}, BIT_MAX ^ cmd_xs_i[2:0]};
            state_d      = BACK_DIVIDE;
          end
        end
      end
      BACK_DIVIDE: begin
        if (div_stat.done) begin
          whole_d    = quo[2:0];
          frac_d     = rem;
          row_step_d = left_q ? rs_stride - rs_qhi : rs_stride + rs_qhi;
          state_d    = BACK_READY;
        end
      end
      default: state_d = BACK_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_READY;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q     <= 8'd40;
      stride_lat_q <= '0;
      ptr_q        <= '0;
      bitpos_q     <= '0;
      err_q        <= '0;
      rows_left_q  <= '0;
      row_step_q   <= '0;
      whole_q      <= '0;
      frac_q       <= '0;
      height_q     <= '0;
      left_q       <= 1'b0;
    end else begin
      stride_q     <= stride_d;
      stride_lat_q <= stride_lat_d;
      ptr_q        <= ptr_d;
      bitpos_q     <= bitpos_d;
      err_q        <= err_d;
      rows_left_q  <= rows_left_d;
      row_step_q   <= row_step_d;
      whole_q      <= whole_d;
      frac_q       <= frac_d;
      height_q     <= height_d;
      left_q       <= left_d;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_push_needs_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> rows_left_q != '0)
    else $error("pixel given with no active edge");

  a_no_pop_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BACK_DIVIDE |-> !cmd_pop_o)
    else $error("command taken while the divider runs");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == BACK_DIVIDE)
    else $error("divider finished outside a begin");

endmodule

/* hw/rtl/bitplane_edge_walker.sv */
// bitplane edge walker: steps along one polygon edge and gives one pixel per
// scanline as a byte address and a bit index (msb-first) in a planar bitmap.
// a func 0 word begins an edge from two end points, a func 1 word gives the
// next pixel and marks the last one with last_row_o; a horizontal edge or a
// step with no active edge gives nothing. words enter a small command queue,
// so the writer sees a queue: push while full is low. results leave through
// a two-word queue: read while empty is low, pop to take the word. row steps
// come out at one per cycle unless the result queue is full or a divide runs.
// a sloped begin holds the back end while an iterative divider forms |dx|/dy
// one quotient bit per cycle. the row stride register (reset 40) is written
// with row_stride_we_i and applies to later begins.
module bitplane_edge_walker import bew_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ADDR_BITS  = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  row_stride_we_i,
  input  logic [7:0]            row_stride_bytes_i,
  // input words
  input  logic                  push,
  output logic                  full,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  // result words
  output logic                  empty,
  input  logic                  pop,
  output logic [ADDR_BITS-1:0]  byte_address_o,
  output logic [2:0]            bit_index_o,
  output logic                  last_row_o
);

  localparam int unsigned KIND_BITS = $bits(bew_kind_t);
  localparam int unsigned CMD_BITS  = KIND_BITS + 4 * COORD_BITS;
  localparam int unsigned RES_BITS  = ADDR_BITS + 4;

  // front end classification
  bew_kind_t             f_kind;
  logic [COORD_BITS-1:0] f_xs, f_ys, f_adx, f_dy;

  // command queue
  logic [CMD_BITS-1:0]   cmd_wdata, cmd_rdata;
  logic                  cmd_empty, cmd_pop;
  bew_kind_t             c_kind;
  logic [COORD_BITS-1:0] c_xs, c_ys, c_adx, c_dy;

  // result queue
  logic                  res_push, res_full;
  logic [ADDR_BITS-1:0]  res_addr;
  logic [2:0]            res_bit;
  logic                  res_last;
  logic [RES_BITS-1:0]   res_rdata;

  bew_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .func_i   (func_i),
    .x_start_i(x_start_i),
    .y_start_i(y_start_i),
    .x_end_i  (x_end_i),
    .y_end_i  (y_end_i),
    .kind_o   (f_kind),
    .xs_o     (f_xs),
    .ys_o     (f_ys),
    .adx_o    (f_adx),
    .dy_o     (f_dy)
  );

  assign cmd_wdata = {f_kind, f_xs, f_ys, f_adx, f_dy};

  // decouples classification from the walk
  bew_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(4)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  assign {c_kind, c_xs, c_ys, c_adx, c_dy} = cmd_rdata;

  bew_back #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stride_we_i(row_stride_we_i),
    .stride_i   (row_stride_bytes_i),
    .cmd_valid_i(!cmd_empty),
    .cmd_kind_i (c_kind),
    .cmd_xs_i   (c_xs),
    .cmd_ys_i   (c_ys),
    .cmd_adx_i  (c_adx),
    .cmd_dy_i   (c_dy),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_addr_o (res_addr),
    .res_bit_o  (res_bit),
    .res_last_o (res_last)
  );

  // output register stage, keeps the walk running while a word waits
  bew_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i({res_last, res_bit, res_addr}),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign {last_row_o, bit_index_o, byte_address_o} = res_rdata;

endmodule

/* sim/bitplane_edge_walker_tb.sv */
module bitplane_edge_walker_tb import bew_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W        = 10;
  localparam int ADDR_W         = 18;
  localparam int SETTLE_CYCLES  = 200;   // covers a queue of begins, each dividing
  localparam int HOLD_CYCLES    = 400;   // long reader stall, fills the block
  localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake at all
  localparam int RANDOM_WORDS   = 930;
  localparam int PHASES         = 4;

  typedef enum logic {
    ROW_WORD,
    ROW_STRIDE
  } row_kind_e;

  // one pixel as the block reports it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_idx;
    logic              last;
  } pixel_t;

  // one line of the directed table; typed rows carry their own expected pixel
  typedef struct packed {
    row_kind_e          kind;
    logic               fn;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic               typed;
    logic               has;
    pixel_t             px;
    logic [7:0]         stride;
  } plan_row_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               row_stride_we_i    = 1'b0;
  logic [7:0]         row_stride_bytes_i = 8'd0;
  logic               push               = 1'b0;
  logic               full;
  logic               func_i             = FUNC_STEP;
  logic [COORD_W-1:0] x_start_i          = '0;
  logic [COORD_W-1:0] y_start_i          = '0;
  logic [COORD_W-1:0] x_end_i            = '0;
  logic [COORD_W-1:0] y_end_i            = '0;
  logic               empty;
  logic               pop                = 1'b0;
  logic [ADDR_W-1:0]  byte_address_o;
  logic [2:0]         bit_index_o;
  logic               last_row_o;

  // sideband that travels with each word: a typed expectation from the table
  logic               dir_typed = 1'b0;
  logic               dir_has   = 1'b0;
  pixel_t             dir_pixel = '0;

  bitplane_edge_walker #(
    .COORD_BITS (COORD_W),
    .ADDR_BITS  (ADDR_W)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .row_stride_we_i    (row_stride_we_i),
    .row_stride_bytes_i (row_stride_bytes_i),
    .push               (push),
    .full               (full),
    .func_i             (func_i),
    .x_start_i          (x_start_i),
    .y_start_i          (y_start_i),
    .x_end_i            (x_end_i),
    .y_end_i            (y_end_i),
    .empty              (empty),
    .pop                (pop),
    .byte_address_o     (byte_address_o),
    .bit_index_o        (bit_index_o),
    .last_row_o         (last_row_o)
  );

  always #6 clk_i = ~clk_i;

  // walker state kept by the testbench
  logic [7:0]          stride_cfg  = 8'd40;
  logic [ADDR_W-1:0]   walk_ptr    = '0;
  logic signed [4:0]   walk_bit    = '0;   // -8..-1 going left, 0..7 going right
  logic signed [11:0]  walk_err    = '0;
  logic [10:0]         rows_left   = '0;   // zero means no edge is active
  logic signed [9:0]   row_step    = '0;
  logic [3:0]          whole_step  = '0;
  logic [10:0]         frac_step   = '0;
  logic [10:0]         edge_height = '0;
  logic                going_left  = 1'b0;

  pixel_t pixels_due[$];
  int     bad_fields   = 0;
  int     live_words   = 0;   // begins plus steps that hit an active edge
  int     quiet_cycles = 0;
  bit     idle_allowed = 1'b1;

  // one accepted word through the walker; made is set when a pixel comes out
  task automatic walk_word(input logic fn, input logic [COORD_W-1:0] xs,
                           input logic [COORD_W-1:0] ys, input logic [COORD_W-1:0] xe,
                           input logic [COORD_W-1:0] ye, output logic made,
                           output pixel_t px);
    logic [COORD_W-1:0] t;
    int dx, dy, adx, quo, rem, b, e, p;
    made = 1'b0;
    px   = '0;
    if (fn == FUNC_BEGIN) begin
      // order the end points so that y grows
      if (ys > ye) begin
        t = xs; xs = xe; xe = t;
        t = ys; ys = ye; ye = t;
      end
      dx = int'(xe) - int'(xs);
      dy = int'(ye) - int'(ys);
      if (dy == 0) begin
        rows_left = '0;   // flat edge, nothing to draw
      end else begin
        adx         = (dx < 0) ? -dx : dx;
        quo         = adx / dy;
        rem         = adx % dy;
        walk_ptr    = ADDR_W'(int'(stride_cfg) * int'(ys) + int'(xs >> 3));
        going_left  = dx < 0;
        whole_step  = 4'(quo % 8);
        frac_step   = 11'(rem);
        edge_height = 11'(dy);
        walk_err    = 12'(-dy);
        rows_left   = 11'(dy);
        b = int'(BIT_MAX) - int'(xs[2:0]);
        // whole bytes of the x step fold into the row step
        if (going_left) begin
          row_step = 10'(int'(stride_cfg) - quo / 8);
          b -= int'(BITS_PER_BYTE);
        end else begin
          row_step = 10'(int'(stride_cfg) + quo / 8);
        end
        walk_bit = 5'(b);
      end
    end else if (rows_left != 0) begin
      made       = 1'b1;
      px.addr    = walk_ptr;
      px.bit_idx = walk_bit[2:0];
      px.last    = rows_left == 11'd1;
      rows_left  = rows_left - 11'd1;
      p = int'(walk_ptr) + int'(row_step);
      e = int'(walk_err) + int'(frac_step);
      b = int'(walk_bit);
      if (!going_left) begin
        if (e >= 0) begin
          b -= 1;
          e -= int'(edge_height);
        end
        b -= int'(whole_step);
        if (b < 0) begin   // carry into the next byte
          p += 1;
          b += int'(BITS_PER_BYTE);
        end
      end else begin
        if (e >= 0) begin
          b += 1;
          e -= int'(edge_height);
        end
        b += int'(whole_step);
        if (b >= 0) begin  // borrow from the previous byte
          p -= 1;
          b -= int'(BITS_PER_BYTE);
        end
      end
      walk_ptr = ADDR_W'(p);
      walk_err = 12'(e);
      walk_bit = 5'(b);
    end
  endtask

  // both handshakes are sampled at the edge, before the block updates
  always @(posedge clk_i) begin : word_monitor
    pixel_t want;
    pixel_t px;
    logic   made;
    if (rst_ni) begin
      if (row_stride_we_i) stride_cfg = row_stride_bytes_i;
      // results first, so a stray pixel cannot pair with a word taken this edge
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          $error("pixel with none expected: addr %0d bit %0d last %0b",
                 byte_address_o, bit_index_o, last_row_o);
          bad_fields++;
        end else begin
          want = pixels_due.pop_front();
          if (byte_address_o !== want.addr) begin
            $error("byte_address: expected %0d, got %0d", want.addr, byte_address_o);
            bad_fields++;
          end
          if (bit_index_o !== want.bit_idx) begin
            $error("bit_index: expected %0d, got %0d", want.bit_idx, bit_index_o);
            bad_fields++;
          end
          if (last_row_o !== want.last) begin
            $error("last_row: expected %0b, got %0b", want.last, last_row_o);
            bad_fields++;
          end
        end
      end
      if (push && !full) begin
        walk_word(func_i, x_start_i, y_start_i, x_end_i, y_end_i, made, px);
        if (dir_typed) begin
          if (dir_has) pixels_due.push_back(dir_pixel);
        end else if (made) begin
          pixels_due.push_back(px);
        end
        if (func_i == FUNC_BEGIN || made) live_words++;
      end
    end
  end

  // watchdog: a run that stops moving ends here
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL bitplane_edge_walker");
      $finish;
    end
  end

  // reader: random idling plus two long stalls that back the block up
  initial begin : result_reader
    int hold_left;
    int taken;
    hold_left = 0;
    taken     = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        taken++;
        if (taken == 150 || taken == 600) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_allowed && $urandom_range(99) < 18);
      end
    end
  end

  function automatic plan_row_t word_row(logic fn, int xs, int ys, int xe, int ye);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.fn   = fn;
    r.xs   = COORD_W'(xs);
    r.ys   = COORD_W'(ys);
    r.xe   = COORD_W'(xe);
    r.ye   = COORD_W'(ye);
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic fn, logic has, int addr, int bidx,
                                          logic last);
    plan_row_t r;
    r            = word_row(fn, 0, 0, 0, 0);
    r.typed      = 1'b1;
    r.has        = has;
    r.px.addr    = ADDR_W'(addr);
    r.px.bit_idx = 3'(bidx);
    r.px.last    = last;
    return r;
  endfunction

  function automatic plan_row_t stride_row(int v);
    plan_row_t r;
    r        = '0;
    r.kind   = ROW_STRIDE;
    r.stride = 8'(v);
    return r;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input plan_row_t w);
    while (idle_allowed && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    func_i    <= w.fn;
    x_start_i <= w.xs;
    y_start_i <= w.ys;
    x_end_i   <= w.xe;
    y_end_i   <= w.ye;
    dir_typed <= w.typed;
    dir_has   <= w.has;
    dir_pixel <= w.px;
    do @(posedge clk_i); while (full);
  endtask

  // stop offering, wait out every expected pixel, then let queued begins finish
  task automatic drain_pixels(input int settle);
    push <= 1'b0;
    @(posedge clk_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_stride(input logic [7:0] v);
    drain_pixels(SETTLE_CYCLES);
    row_stride_we_i    <= 1'b1;
    row_stride_bytes_i <= v;
    @(posedge clk_i);
    row_stride_we_i    <= 1'b0;
  endtask

  // mostly whole edges with random geometry, some cut short or overrun,
  // plus stray steps and flat edges
  task automatic send_random_edge();
    int sel, dy, steps, xs, ys, xe, ye, t;
    sel = $urandom_range(99);
    if (sel < 8) begin
      send_word(word_row(FUNC_STEP, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023), $urandom_range(1023)));
      return;
    end
    xs = $urandom_range(1023);
    ys = $urandom_range(1023);
    if (sel < 14) begin
      send_word(word_row(FUNC_BEGIN, xs, ys, $urandom_range(1023), ys));
      send_word(word_row(FUNC_STEP, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023), $urandom_range(1023)));
      return;
    end
    sel = $urandom_range(99);
    if (sel < 75)      dy = $urandom_range(8, 1);
    else if (sel < 97) dy = $urandom_range(40, 9);
    else               dy = $urandom_range(300, 41);
    ye = (ys + dy > 1023) ? ys - dy : ys + dy;
    if ($urandom_range(1)) begin
      xe = $urandom_range(1023);
    end else begin
      xe = xs + $urandom_range(6 * dy) - 3 * dy;
      if (xe < 0)    xe = 0;
      if (xe > 1023) xe = 1023;
    end
    if ($urandom_range(1)) begin
      t = xs; xs = xe; xe = t;
      t = ys; ys = ye; ye = t;
    end
    send_word(word_row(FUNC_BEGIN, xs, ys, xe, ye));
    sel   = $urandom_range(99);
    steps = dy;
    if (sel < 10)      steps = $urandom_range(dy - 1);
    else if (sel < 18) steps = dy + $urandom_range(2, 1);
    repeat (steps)
      send_word(word_row(FUNC_STEP, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023), $urandom_range(1023)));
  endtask

  initial begin : stimulus
    plan_row_t plan[$];
    int        stride_plan[PHASES];
    int        goal;
    bit        paused;
    paused = 1'b0;

    // stride starts at its reset value of 40
    plan.push_back(word_row(FUNC_BEGIN, 0, 0, 0, 1));
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 0, 7, 1'b1));
    plan.push_back(typed_row(FUNC_STEP, 1'b0, 0, 0, 1'b0));        // edge used up
    plan.push_back(word_row(FUNC_BEGIN, 1023, 1023, 1023, 1022));  // swapped ends
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 41007, 0, 1'b1));
    plan.push_back(word_row(FUNC_BEGIN, 5, 100, 900, 100));        // flat edge
    plan.push_back(typed_row(FUNC_STEP, 1'b0, 0, 0, 1'b0));
    plan.push_back(word_row(FUNC_BEGIN, 0, 0, 0, 5));
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 0, 7, 1'b0));
    plan.push_back(word_row(FUNC_BEGIN, 0, 0, 1023, 1));           // replaces live edge
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 0, 7, 1'b1));
    plan.push_back(word_row(FUNC_BEGIN, 1023, 0, 0, 1));           // widest left step
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 127, 0, 1'b1));
    plan.push_back(word_row(FUNC_BEGIN, 0, 1023, 1023, 0));        // full diagonal
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 127, 0, 1'b0));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));
    plan.push_back(stride_row(255));
    plan.push_back(word_row(FUNC_BEGIN, 0, 1020, 1023, 1023));     // bottom rows
    plan.push_back(typed_row(FUNC_STEP, 1'b1, 260100, 7, 1'b0));
    plan.push_back(word_row(FUNC_STEP, 1023, 1023, 1023, 1023));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));
    plan.push_back(stride_row(0));                                 // all rows overlap
    plan.push_back(word_row(FUNC_BEGIN, 7, 0, 0, 3));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));
    plan.push_back(stride_row(1));
    plan.push_back(word_row(FUNC_BEGIN, 3, 10, 700, 14));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));
    plan.push_back(word_row(FUNC_STEP, 0, 0, 0, 0));

    stride_plan[0] = $urandom_range(254, 2);
    stride_plan[1] = 255;
    stride_plan[2] = 1;
    stride_plan[3] = $urandom_range(255, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_STRIDE) write_stride(plan[i].stride);
      else send_word(plan[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_stride(8'(stride_plan[ph]));
      idle_allowed = (ph != 2);   // one phase runs both sides flat out
      goal = live_words + RANDOM_WORDS / PHASES;
      while (live_words < goal) begin
        send_random_edge();
        // once, halfway through a phase, the writer stops until all is out
        if (ph == 1 && !paused && live_words > goal - RANDOM_WORDS / (2 * PHASES)) begin
          drain_pixels(0);
          paused = 1'b1;
        end
      end
    end

    drain_pixels(SETTLE_CYCLES);
    if (bad_fields == 0) $display("PASS bitplane_edge_walker");
    else $display("FAIL bitplane_edge_walker");
    $finish;
  end

endmodule
